FILE: design/tlbcr_pkg.sv
package tlbcr_pkg;

  localparam int TLB_ENTRIES = 4;
  localparam int VPN_BITS    = 16;
  localparam int PPN_BITS    = 16;
  localparam int HAND_W      = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  typedef enum logic {
    OP_FILL = 1'b0,
    OP_REF  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [1:0]  ref_slot;
    logic [15:0] entry_vpn;
    logic [15:0] entry_ppn;
    logic        entry_valid;
    logic        entry_read_only;
    logic        entry_dirty;
  } in_t;

  typedef struct packed {
    logic [1:0]  slot;
    logic        evicted_valid;
    logic [15:0] evicted_vpn;
  } out_t;

  // sequencer -> entry store
  typedef struct packed {
    logic              use_set;
    logic              use_clr;
    logic              wr;
    logic [HAND_W-1:0] idx;
  } store_ctl_t;

  // entry store -> sequencer, slot under idx
  typedef struct packed {
    logic                valid;
    logic                use_bit;
    logic [VPN_BITS-1:0] vpn;
  } store_rd_t;

endpackage

FILE: design/tlbcr_store.sv
module tlbcr_store
  import tlbcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_ctl_t ctl,
  input  in_t        wr_item,
  output store_rd_t  rd
);

  logic [VPN_BITS-1:0] vpn_r       [TLB_ENTRIES];
  logic [PPN_BITS-1:0] ppn_r       [TLB_ENTRIES];
  logic                dirty_r     [TLB_ENTRIES];
  logic                read_only_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_r;
  logic [TLB_ENTRIES-1:0] use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      use_r   <= '0;
    end else begin
      if (ctl.wr) begin
        valid_r[ctl.idx] <= wr_item.entry_valid;
        use_r[ctl.idx]   <= 1'b1;
      end else if (ctl.use_clr) begin
        use_r[ctl.idx] <= 1'b0;
      end else if (ctl.use_set) begin
        use_r[ctl.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      vpn_r[ctl.idx]       <= VPN_BITS'(wr_item.entry_vpn);
      ppn_r[ctl.idx]       <= PPN_BITS'(wr_item.entry_ppn);
      dirty_r[ctl.idx]     <= wr_item.entry_dirty;
      read_only_r[ctl.idx] <= wr_item.entry_read_only;
    end
  end

  assign rd.valid   = valid_r[ctl.idx];
  assign rd.use_bit = use_r[ctl.idx];
  assign rd.vpn     = vpn_r[ctl.idx];

endmodule

FILE: design/tlbcr_seq.sv
module tlbcr_seq
  import tlbcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  output store_ctl_t ctl,
  output in_t        wr_item,
  input  store_rd_t  rd
);

  state_t            state_r, state_nxt;
  logic [HAND_W-1:0] hand_r, hand_nxt;
  in_t               item_r, item_nxt;
  out_t              out_r, out_nxt;

  logic              in_beat;
  logic              ref_in_range;
  logic              second_chance;
  logic [HAND_W-1:0] hand_inc;

  assign in_beat       = in_valid && in_ready;
  assign ref_in_range  = 32'(in_data.ref_slot) < TLB_ENTRIES;
  assign second_chance = rd.valid && rd.use_bit;
  assign hand_inc      = (hand_r == HAND_W'(TLB_ENTRIES - 1)) ? '0 : hand_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = (in_data.opcode == OP_REF) ? ST_RESP : ST_SCAN;
      end
      ST_SCAN: begin
        if (!second_chance) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and store control
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctl.use_set = 1'b0;
    ctl.use_clr = 1'b0;
    ctl.wr      = 1'b0;
    ctl.idx     = hand_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // ready is always high here, so valid alone marks the beat
        if (in_valid && in_data.opcode == OP_REF) begin
          ctl.idx     = HAND_W'(in_data.ref_slot);
          ctl.use_set = ref_in_range;
        end
      end
      ST_SCAN: begin
        // valid + used: clear and move on; otherwise this is the victim
        ctl.use_clr = second_chance;
        ctl.wr      = !second_chance;
      end
      ST_RESP: out_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    hand_nxt = hand_r;
    item_nxt = item_r;
    out_nxt  = out_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          item_nxt              = in_data;
          out_nxt.slot          = in_data.ref_slot;
          out_nxt.evicted_valid = 1'b0;
          out_nxt.evicted_vpn   = '0;
        end
      end
      ST_SCAN: begin
        if (second_chance) begin
          hand_nxt = hand_inc;
        end else begin
          out_nxt.slot          = 2'(hand_r);
          out_nxt.evicted_valid = rd.valid;
          out_nxt.evicted_vpn   = rd.valid ? 16'(rd.vpn) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hand_r  <= '0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;
  assign wr_item  = item_r;

endmodule

FILE: design/tlb_clock_replacement.sv
// channel  ports                              beat
// -------  ---------------------------------  ------------------------------
// input    in_valid, in_ready, in_data        one fill or reference command
// output   out_valid, out_ready, out_data     slot and evicted entry
//
// Reference: the result is offered in the cycle after accept.
// Fill: accepted, then a scan through the entry store (one slot examined per
// cycle under the clock hand) until an invalid or unused slot is found; that
// slot is written and then the result is offered.
// in_ready is low from accept until the result beat is taken.
// rst_n (sync) empties the TLB and returns the hand to slot 0.
module tlb_clock_replacement
  import tlbcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  store_ctl_t ctl;
  store_rd_t  rd;
  in_t        wr_item;

  tlbcr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ctl       (ctl),
    .wr_item   (wr_item),
    .rd        (rd)
  );

  tlbcr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_item (wr_item),
    .rd      (rd)
  );

endmodule
